// ===== rtl/ekm_pkg.sv =====
// ekm_pkg: shared types, codes and reset values for the keepalive echo monitor
// no dependencies; imported by ekm_step and echo_keepalive_monitor_unit
package ekm_pkg;

   localparam int TIME_W     = 48;
   localparam int INTV_W     = 16;
   localparam int HINT_W     = 16;
   localparam int SEQ_W      = 16;
   localparam int MISS_W     = 8;
   localparam int PHASE_W    = 2;
   localparam int STATUS_W   = 2;
   localparam int OUTCOME_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_BLOCKED = 2'd1;
   localparam logic [PHASE_W-1:0] PH_AWAIT   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_PAUSE   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

   localparam logic [OUTCOME_W-1:0] SEND_OK    = 2'd0;
   localparam logic [OUTCOME_W-1:0] SEND_BLOCK = 2'd1;
   localparam logic [OUTCOME_W-1:0] RECV_REPLY = 2'd0;
   localparam logic [OUTCOME_W-1:0] RECV_NONE  = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_RETRY      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKED    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_LIMIT = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0]    now_ms;
      logic [OUTCOME_W-1:0] send_outcome;
      logic [OUTCOME_W-1:0] recv_outcome;
      logic [HINT_W-1:0]    wait_hint_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                request_sent;
      logic [SEQ_W-1:0]    sent_sequence;
      logic                reply_seen;
      logic [HINT_W-1:0]   wait_hint_out;
   } rsp_type;

   typedef struct packed {
      logic [INTV_W-1:0] retry_interval_ms;
      logic [INTV_W-1:0] cycle_interval_ms;
      logic [INTV_W-1:0] blocked_limit_ms;
      logic [INTV_W-1:0] reply_limit_ms;
      logic [MISS_W-1:0] miss_limit;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [TIME_W-1:0]  last_event_time;
      logic [TIME_W-1:0]  next_event_time;
      logic [MISS_W-1:0]  miss_count;
      logic [SEQ_W-1:0]   sequence_counter;
   } state_type;

   localparam cfg_type CFG_RST = '{
      retry_interval_ms: 16'd1000,
      cycle_interval_ms: 16'd15000,
      blocked_limit_ms:  16'd5000,
      reply_limit_ms:    16'd5000,
      miss_limit:        8'd3
   };

   localparam state_type STATE_RST = '{
      phase:            PH_IDLE,
      last_event_time:  '0,
      next_event_time:  '0,
      miss_count:       '0,
      sequence_counter: '0
   };

endpackage

// ===== rtl/echo_keepalive_monitor_unit.sv =====
// echo_keepalive_monitor_unit: top level, request and response registers, csr bank
// depends on ekm_pkg and ekm_step
//
// Each request on req_data is one poll: current ms time, the send and receive
// outcomes, and the caller's wait bound. Each request yields exactly one
// response on rsp_data: status, request sent and its sequence number, reply
// seen, and the updated wait bound.
// A request is taken at a clock edge with req_valid high and req_stall low;
// a response is taken with rsp_valid high and rsp_stall low.
// A request moves from the request register into the response register, which
// drives rsp_valid. Throughput is one request per cycle unless a stalled response
// holds the flow: the whole poll step, three 48-bit compares and a few 48-bit
// adds, sits between the two registers, and the monitor state updates with it.
// While the receiver stalls, the held response stays put and one more request
// is held in the request register; req_stall rises only when both are full.
// Registers are written through csr_wr_en, csr_index and csr_wdata; the user
// writes only while no request is in flight (the block does not enforce this);
// indexes past the last register are ignored. Synchronous reset restores the
// register defaults, sets the phase to idle, clears both event times, the miss
// count and the sequence counter, and empties both pipeline registers.
module echo_keepalive_monitor_unit import ekm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in, state_step;
   logic      req_valid_ff, req_valid_in;
   req_type   req_data_ff, req_data_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in, rsp_step;
   logic      advance, req_take;

   ekm_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (req_data_ff),
      .state_next (state_step),
      .result     (rsp_step)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign req_data_in  = req_take ? req_data : req_data_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = advance ? rsp_step : rsp_data_ff;
   assign state_in     = advance ? state_step : state_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RETRY:      cfg_in.retry_interval_ms = csr_wdata[INTV_W-1:0];
            CSR_CYCLE:      cfg_in.cycle_interval_ms = csr_wdata[INTV_W-1:0];
            CSR_BLOCKED:    cfg_in.blocked_limit_ms  = csr_wdata[INTV_W-1:0];
            CSR_REPLY:      cfg_in.reply_limit_ms    = csr_wdata[INTV_W-1:0];
            CSR_MISS_LIMIT: cfg_in.miss_limit        = csr_wdata[MISS_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RST;
         state_ff     <= STATE_RST;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_seq_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.request_sent || rsp_data_ff.sent_sequence == '0))
      else $error("sequence reported without a request sent");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_step.request_sent) |=>
      state_ff.sequence_counter == SEQ_W'($past(state_ff.sequence_counter) + 1'b1))
      else $error("sequence counter did not advance after a send");

   a_miss_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_step.status == ST_MISS) |=>
      (state_ff.phase == PH_IDLE && state_ff.miss_count == '0 &&
       state_ff.last_event_time == '0 && state_ff.next_event_time == '0))
      else $error("miss timeout did not clear the monitor state");

   // a zero reply limit can count a fresh miss after the reply in the same poll
   a_reply_clears_miss: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_step.reply_seen && cfg_ff.reply_limit_ms != '0) |=>
      state_ff.miss_count == '0)
      else $error("miss count kept after a reply");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("monitor state changed without a request");

endmodule

// ===== rtl/ekm_step.sv =====
// ekm_step: next state and result of one poll, all deadline compares in parallel
// depends on ekm_pkg
module ekm_step import ekm_pkg::*; (
   input  cfg_type   cfg,
   input  state_type state,
   input  req_type   item,
   output state_type state_next,
   output rsp_type   result
);

   function automatic logic [MISS_W-1:0] miss_inc(input logic [MISS_W-1:0] m);
      return (m == '1) ? m : MISS_W'(m + 1'b1);
   endfunction

   function automatic logic [TIME_W:0] widen(input logic [INTV_W-1:0] v);
      return {{(TIME_W+1-INTV_W){1'b0}}, v};
   endfunction

   logic [TIME_W:0]   blk_sum, rep_sum, retry_sum, cyc_sum;
   logic              blk_exp, rep_exp, pend, pause_hold;
   logic [TIME_W-1:0] gap, now_room, retry_next, cyc_next;
   logic [HINT_W-1:0] pend_hint, retry_hint, cyc_gap, cyc_hint;
   logic              do_send, keep_last;

   assign blk_sum   = {1'b0, state.last_event_time} + widen(cfg.blocked_limit_ms);
   assign rep_sum   = {1'b0, state.last_event_time} + widen(cfg.reply_limit_ms);
   assign blk_exp   = {1'b0, item.now_ms} >= blk_sum;
   assign rep_exp   = {1'b0, item.now_ms} >= rep_sum;

   assign pend      = (state.next_event_time != '0) && (item.now_ms < state.next_event_time);
   assign gap       = state.next_event_time - item.now_ms;
   assign pend_hint = (gap[TIME_W-1:HINT_W] != '0) ? '1 : gap[HINT_W-1:0];

   assign retry_sum  = {1'b0, item.now_ms} + widen(cfg.retry_interval_ms);
   assign retry_next = retry_sum[TIME_W] ? '1 : retry_sum[TIME_W-1:0];
   assign retry_hint = (item.wait_hint_in > cfg.retry_interval_ms) ?
                       cfg.retry_interval_ms : item.wait_hint_in;

   // saturated deadline stays ahead of now unless the interval is zero or time is at max
   assign cyc_sum    = {1'b0, item.now_ms} + widen(cfg.cycle_interval_ms);
   assign cyc_next   = cyc_sum[TIME_W] ? '1 : cyc_sum[TIME_W-1:0];
   assign now_room   = ~item.now_ms;
   assign cyc_gap    = ((now_room[TIME_W-1:HINT_W] != '0) ||
                        (now_room[HINT_W-1:0] > cfg.cycle_interval_ms)) ?
                       cfg.cycle_interval_ms : now_room[HINT_W-1:0];
   assign pause_hold = (cfg.cycle_interval_ms != '0) && (item.now_ms != '1);
   assign cyc_hint   = (item.wait_hint_in > cyc_gap) ? cyc_gap : item.wait_hint_in;

   always_comb begin
      state_next           = state;
      result.status        = ST_OK;
      result.request_sent  = 1'b0;
      result.sent_sequence = '0;
      result.reply_seen    = 1'b0;
      result.wait_hint_out = item.wait_hint_in;
      do_send              = 1'b0;
      keep_last            = 1'b0;

      if (pend) begin
         result.wait_hint_out = pend_hint;
      end else begin
         unique case (state.phase)
            PH_IDLE: begin
               do_send = 1'b1;
            end
            PH_BLOCKED: begin
               if (blk_exp) begin
                  result.status = ST_FAIL;
               end else begin
                  do_send   = 1'b1;
                  keep_last = 1'b1;
               end
            end
            PH_AWAIT: begin
               if (rep_exp) begin
                  if (state.miss_count > cfg.miss_limit) begin
                     result.status = ST_MISS;
                     state_next.phase = PH_IDLE;
                     state_next.miss_count = '0;
                     state_next.last_event_time = '0;
                     state_next.next_event_time = '0;
                  end else begin
                     state_next.miss_count = miss_inc(state.miss_count);
                     state_next.phase = PH_IDLE;
                     state_next.last_event_time = item.now_ms;
                     state_next.next_event_time = item.now_ms;
                     do_send = 1'b1;
                  end
               end else begin
                  case (item.recv_outcome)
                     RECV_REPLY: begin
                        result.reply_seen = 1'b1;
                        state_next.miss_count = '0;
                        state_next.last_event_time = item.now_ms;
                        if (pause_hold) begin
                           state_next.phase = PH_PAUSE;
                           state_next.next_event_time = cyc_next;
                           result.wait_hint_out = cyc_hint;
                        end else begin
                           state_next.phase = PH_IDLE;
                           state_next.next_event_time = item.now_ms;
                           do_send = 1'b1;
                        end
                     end
                     RECV_NONE: begin
                        state_next.next_event_time = retry_next;
                        result.wait_hint_out = retry_hint;
                     end
                     default: begin
                        result.status = ST_FAIL;
                     end
                  endcase
               end
            end
            PH_PAUSE: begin
               state_next.phase = PH_IDLE;
               state_next.last_event_time = item.now_ms;
               state_next.next_event_time = item.now_ms;
               do_send = 1'b1;
            end
         endcase
      end

      if (do_send) begin
         case (item.send_outcome)
            SEND_OK: begin
               result.request_sent = 1'b1;
               result.sent_sequence = state.sequence_counter;
               state_next.sequence_counter = SEQ_W'(state.sequence_counter + 1'b1);
               state_next.last_event_time = item.now_ms;
               state_next.next_event_time = item.now_ms;
               // reply wait right after the send
               if (cfg.reply_limit_ms == '0) begin
                  if (state_next.miss_count > cfg.miss_limit) begin
                     result.status = ST_MISS;
                     state_next.phase = PH_IDLE;
                     state_next.miss_count = '0;
                     state_next.last_event_time = '0;
                     state_next.next_event_time = '0;
                  end else begin
                     state_next.miss_count = miss_inc(state_next.miss_count);
                     state_next.phase = PH_IDLE;
                     result.wait_hint_out = '0;
                  end
               end else begin
                  case (item.recv_outcome)
                     RECV_REPLY: begin
                        result.reply_seen = 1'b1;
                        state_next.miss_count = '0;
                        if (pause_hold) begin
                           state_next.phase = PH_PAUSE;
                           state_next.next_event_time = cyc_next;
                           result.wait_hint_out = cyc_hint;
                        end else begin
                           state_next.phase = PH_IDLE;
                           result.wait_hint_out = '0;
                        end
                     end
                     RECV_NONE: begin
                        state_next.phase = PH_AWAIT;
                        state_next.next_event_time = retry_next;
                        result.wait_hint_out = retry_hint;
                     end
                     default: begin
                        state_next.phase = PH_AWAIT;
                        result.status = ST_FAIL;
                     end
                  endcase
               end
            end
            SEND_BLOCK: begin
               state_next.phase = PH_BLOCKED;
               if (!keep_last) begin
                  state_next.last_event_time = item.now_ms;
               end
               state_next.next_event_time = retry_next;
               result.wait_hint_out = retry_hint;
            end
            default: begin
               result.status = ST_FAIL;
            end
         endcase
      end
   end

endmodule
